// ----- rtl/core/hog_cell_orientation_histogram_core_macros.svh -----
`ifndef HOG_CELL_ORIENTATION_HISTOGRAM_CORE_MACROS_SVH
`define HOG_CELL_ORIENTATION_HISTOGRAM_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define HOGC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define HOGC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/hogc_pkg.sv -----
package hogc_pkg;

  localparam int IMAGE_SIZE     = 128;
  localparam int CELL_SIZE      = 8;
  localparam int CELLS_PER_SIDE = 15;
  localparam int NUM_BINS       = 9;
  localparam int FRACTION_BITS  = 15;

  localparam int HALF_BINS  = NUM_BINS / 2;
  localparam int TAN_COUNT  = 4;
  localparam int CELL_SPAN  = CELLS_PER_SIDE * CELL_SIZE;
  localparam int COL_W      = $clog2(IMAGE_SIZE);
  localparam int CNT_DEPTH  = CELLS_PER_SIDE * NUM_BINS;
  localparam int CNT_AW     = $clog2(CNT_DEPTH);
  localparam int CNT_W      = 7;
  localparam int CIDX_W     = 4;
  localparam int BIN_W      = 4;
  localparam int SUM_W      = 13;
  localparam int VAL_W      = FRACTION_BITS + 1;
  localparam int T_W        = FRACTION_BITS + 1;
  localparam int TT_W       = 2 * T_W;
  localparam int PROD_W     = TT_W + SUM_W;
  localparam int TAN_W      = 35;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

  localparam logic [TAN_W-1:0] BOUND_TAN [TAN_COUNT] = '{
    35'd1563240253, 35'd3603905474, 35'd7439101574, 35'd24357969942
  };

  typedef struct packed {
    logic [CIDX_W-1:0]                cell_row;
    logic [CIDX_W-1:0]                cell_col;
    logic [NUM_BINS-1:0][CNT_W-1:0]   counts;
  } cell_rec_t;

  function automatic logic [BIN_W-1:0] orient_bin(input logic signed [8:0] gx_in,
                                                  input logic signed [8:0] gy_in);
    logic signed [9:0] gx;
    logic signed [9:0] gy;
    logic [TAN_W+7:0]  ys;
    logic [TAN_W+7:0]  prod;
    logic [7:0]        a;
    logic [BIN_W-1:0]  b;
    gx = 10'(gx_in);
    gy = 10'(gy_in);
    if (gy < 0) begin
      gx = -gx;
      gy = -gy;
    end
    ys = {3'b000, gy[7:0], 32'h0};
    a  = (gx < 0) ? 8'(-gx) : 8'(gx);
    if (gy == 0) begin
      b = '0;
    end else if (gx > 0) begin
      b = '0;
      for (int k = 0; k < TAN_COUNT; k++) begin
        prod = (TAN_W+8)'(BOUND_TAN[k]) * (TAN_W+8)'(a);
        if (ys >= prod) b = b + BIN_W'(1);
      end
    end else if (gx == 0) begin
      b = BIN_W'(HALF_BINS);
    end else begin
      b = BIN_W'(HALF_BINS);
      for (int k = 0; k < TAN_COUNT; k++) begin
        prod = (TAN_W+8)'(BOUND_TAN[k]) * (TAN_W+8)'(a);
        if (ys < prod) b = b + BIN_W'(1);
      end
    end
    return b;
  endfunction

endpackage

// ----- rtl/core/hogc_front.sv -----
module hogc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          pixel,
  input  logic                frame_start,
  output logic                rec_valid,
  input  logic                rec_ready,
  output hogc_pkg::cell_rec_t rec
);
  import hogc_pkg::*;

  typedef enum logic [5:0] {
    F_IDLE  = 6'b000001,
    F_GRAD  = 6'b000010,
    F_BIN   = 6'b000100,
    F_INC   = 6'b001000,
    F_DRAIN = 6'b010000,
    F_PUSH  = 6'b100000
  } fstate_t;

  fstate_t state;
  logic [COL_W-1:0] row_pos, col_pos, row_q, col_q;
  logic [COL_W-1:0] cur_row, cur_col, cur_col_n, gr;
  logic [7:0] pix_q, left_pixel, nw_c, nw_n, od_c;
  logic [7:0] newer_mem [IMAGE_SIZE];
  logic [7:0] older_mem [IMAGE_SIZE];
  logic signed [8:0] gx, gy, gx_q, gy_q;
  logic [CIDX_W-1:0] cc_q;
  logic done_q;
  logic accept;
  logic [CNT_W-1:0] cnt_mem [CNT_DEPTH];
  logic [CNT_DEPTH-1:0] cnt_valid;
  logic [CNT_W-1:0] cnt_rd, cnt_val;
  logic cnt_vld_rd;
  logic [CNT_AW-1:0] base, cnt_raddr, cnt_waddr;
  logic [BIN_W-1:0] dk;

  assign accept    = in_valid && (state == F_IDLE);
  assign in_stall  = (state != F_IDLE);
  assign rec_valid = (state == F_PUSH);
  assign cur_row   = frame_start ? '0 : row_pos;
  assign cur_col   = frame_start ? '0 : col_pos;
  assign cur_col_n = cur_col + COL_W'(1);
  assign gr        = row_q - COL_W'(1);
  assign base      = CNT_AW'(cc_q) * CNT_AW'(NUM_BINS);
  assign cnt_val   = cnt_vld_rd ? cnt_rd : '0;

  always_comb begin
    gy = (row_q == COL_W'(1)) ? 9'sd0 : $signed({1'b0, pix_q}) - $signed({1'b0, od_c});
    gx = (col_q == '0 || col_q == COL_W'(IMAGE_SIZE - 1)) ? 9'sd0 :
         $signed({1'b0, nw_n}) - $signed({1'b0, left_pixel});
  end

  always_comb begin
    if (state == F_DRAIN && dk < BIN_W'(NUM_BINS)) begin
      cnt_raddr = base + CNT_AW'(dk);
    end else if (state == F_DRAIN) begin
      cnt_raddr = base;
    end else begin
      cnt_raddr = base + CNT_AW'(orient_bin(gx_q, gy_q));
    end
  end

  // line buffers
  always_ff @(posedge clk) begin
    nw_c <= newer_mem[cur_col];
    nw_n <= newer_mem[cur_col_n];
    od_c <= older_mem[cur_col];
    if (state == F_GRAD) begin
      newer_mem[col_q] <= pix_q;
      if (row_q != '0) begin
        older_mem[col_q] <= nw_c;
      end
    end
  end

  // cell count memory
  always_ff @(posedge clk) begin
    cnt_rd     <= cnt_mem[cnt_raddr];
    cnt_vld_rd <= cnt_valid[cnt_raddr];
    if (state == F_INC) begin
      cnt_mem[cnt_waddr] <= cnt_val + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_q <= pixel;
      row_q <= cur_row;
      col_q <= cur_col;
    end
    if (state == F_GRAD) begin
      gx_q   <= gx;
      gy_q   <= gy;
      cc_q   <= CIDX_W'(col_q / CELL_SIZE);
      done_q <= (gr % CELL_SIZE == CELL_SIZE - 1) && (col_q % CELL_SIZE == CELL_SIZE - 1);
      rec.cell_row <= CIDX_W'(gr / CELL_SIZE);
      rec.cell_col <= CIDX_W'(col_q / CELL_SIZE);
      if (row_q != '0) begin
        left_pixel <= nw_c;
      end
    end
    if (state == F_BIN) begin
      cnt_waddr <= cnt_raddr;
    end
    if (state == F_DRAIN && dk != '0) begin
      rec.counts[dk - BIN_W'(1)] <= cnt_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      row_pos   <= '0;
      col_pos   <= '0;
      cnt_valid <= '0;
      dk        <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            if (cur_col == COL_W'(IMAGE_SIZE - 1)) begin
              col_pos <= '0;
              row_pos <= (cur_row == COL_W'(IMAGE_SIZE - 1)) ? '0 : cur_row + COL_W'(1);
            end else begin
              col_pos <= cur_col + COL_W'(1);
              row_pos <= cur_row;
            end
            if (frame_start || (cur_row == COL_W'(IMAGE_SIZE - 1) &&
                                cur_col == COL_W'(IMAGE_SIZE - 1))) begin
              cnt_valid <= '0;
            end
            state <= F_GRAD;
          end
        end
        F_GRAD: begin
          if (row_q != '0 && gr < COL_W'(CELL_SPAN) && col_q < COL_W'(CELL_SPAN)) begin
            state <= F_BIN;
          end else begin
            state <= F_IDLE;
          end
        end
        F_BIN: begin
          state <= F_INC;
        end
        F_INC: begin
          cnt_valid[cnt_waddr] <= 1'b1;
          dk <= '0;
          state <= done_q ? F_DRAIN : F_IDLE;
        end
        F_DRAIN: begin
          if (dk < BIN_W'(NUM_BINS)) begin
            cnt_valid[cnt_raddr] <= 1'b0;
          end
          if (dk == BIN_W'(NUM_BINS)) begin
            state <= F_PUSH;
          end else begin
            dk <= dk + BIN_W'(1);
          end
        end
        F_PUSH: begin
          if (rec_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/hogc_fifo.sv -----
module hogc_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  hogc_pkg::cell_rec_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output hogc_pkg::cell_rec_t pop_data
);
  import hogc_pkg::*;

  cell_rec_t entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0] fill;
  logic do_push, do_pop;

  assign push_ready = (fill != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (do_push && !do_pop) begin
        fill <= fill + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// ----- rtl/core/hogc_norm.sv -----
`include "hog_cell_orientation_histogram_core_macros.svh"

module hogc_norm (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rec_valid,
  output logic                         rec_ready,
  input  hogc_pkg::cell_rec_t          rec,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [hogc_pkg::CIDX_W-1:0]  cell_row,
  output logic [hogc_pkg::CIDX_W-1:0]  cell_col,
  output logic [hogc_pkg::BIN_W-1:0]   bin_index,
  output logic [hogc_pkg::CNT_W-1:0]   bin_count,
  output logic [hogc_pkg::VAL_W-1:0]   bin_value,
  output logic                         last_bin
);
  import hogc_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_SUM  = 5'b00010,
    B_INIT = 5'b00100,
    B_MID  = 5'b01000,
    B_CMP  = 5'b10000
  } bstate_t;

  bstate_t state;
  logic out_q;
  cell_rec_t cur;
  logic [BIN_W-1:0] k;
  logic [SUM_W-1:0] s, c_sq;
  logic [VAL_W-1:0] lo, hi, mid, mid_q;
  logic [VAL_W:0] span;
  logic [T_W-1:0] t;
  logic [TT_W-1:0] tt;
  logic [PROD_W-1:0] lhs, rhs;
  logic [CNT_W-1:0] ck;

  assign ck        = cur.counts[k];
  assign rec_ready = (state == B_IDLE) && !out_q;
  assign span      = (VAL_W+1)'(hi) - (VAL_W+1)'(lo) + (VAL_W+1)'(1);
  assign mid       = lo + VAL_W'(span >> 1);
  assign t         = T_W'({mid, 1'b0} - (VAL_W+1)'(1));
  assign lhs       = PROD_W'(tt) * PROD_W'(s);
  assign rhs       = {c_sq, TT_W'(0)};

  assign out_valid = out_q;
  assign cell_row  = cur.cell_row;
  assign cell_col  = cur.cell_col;
  assign bin_index = k;
  assign bin_count = ck;
  assign bin_value = lo;
  assign last_bin  = (k == BIN_W'(NUM_BINS - 1));

  always_ff @(posedge clk) begin
    if (rec_valid && rec_ready) cur <= rec;
    if (state == B_MID) begin
      tt    <= TT_W'(t) * TT_W'(t);
      mid_q <= mid;
    end
    if (state == B_INIT) begin
      c_sq <= SUM_W'((2*CNT_W)'(ck) * (2*CNT_W)'(ck));
      lo   <= '0;
      hi   <= (s == '0) ? '0 : VAL_W'(1) << FRACTION_BITS;
    end
    if (state == B_CMP) begin
      if (lhs <= rhs) begin
        lo <= mid_q;
      end else begin
        hi <= mid_q - VAL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_q <= 1'b0;
      k     <= '0;
      s     <= '0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (out_q) begin
            if (!out_stall) begin
              out_q <= 1'b0;
              if (!last_bin) begin
                k <= k + BIN_W'(1);
                state <= B_INIT;
              end
            end
          end else if (rec_valid) begin
            k <= '0;
            s <= '0;
            state <= B_SUM;
          end
        end
        B_SUM: begin
          s <= s + SUM_W'((2*CNT_W)'(ck) * (2*CNT_W)'(ck));
          if (k == BIN_W'(NUM_BINS - 1)) begin
            k <= '0;
            state <= B_INIT;
          end else begin
            k <= k + BIN_W'(1);
          end
        end
        B_INIT: state <= B_MID;
        B_MID: begin
          if (lo == hi) begin
            out_q <= 1'b1;
            state <= B_IDLE;
          end else begin
            state <= B_CMP;
          end
        end
        B_CMP: state <= B_MID;
        default: state <= B_IDLE;
      endcase
    end
  end

  `HOGC_ASSERT_IMP(a_search_bounds, state == B_CMP, (mid_q > lo) && (mid_q <= hi), "search midpoint out of range")
  `HOGC_ASSERT_IMP(a_zero_count, out_valid, (bin_count == '0) == (bin_value == '0), "zero count and zero value disagree")
  `HOGC_ASSERT_NXT(a_bin_advance, out_valid && !out_stall && !last_bin, state == B_INIT, "next bin not started")

endmodule

// ----- rtl/core/hog_cell_orientation_histogram_core.sv -----
// flow: a cell is finished by the pixel below its bottom right pixel; each pixel is taken only
//   while the front is idle and passes the gradient state, inside a cell also bin and increment
//   states, plus drain and push when a cell completes; the normalizer sums the squared counts,
//   then binary searches each bin's value in midpoint and compare steps, behind a two-cell queue;
//   a finished cell that finds the queue full holds the input until a slot frees
// reset: rst synchronous active high clears positions, count valid bits, queue and control
module hog_cell_orientation_histogram_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  pixel,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  cell_row,
  output logic [3:0]  cell_col,
  output logic [3:0]  bin_index,
  output logic [6:0]  bin_count,
  output logic [15:0] bin_value,
  output logic        last_bin
);
  import hogc_pkg::*;

  cell_rec_t f_rec, q_rec;
  logic f_valid, f_ready, q_valid, q_ready;

  hogc_front u_front (
    .clk, .rst, .in_valid, .in_stall, .pixel, .frame_start,
    .rec_valid(f_valid), .rec_ready(f_ready), .rec(f_rec)
  );

  hogc_fifo u_fifo (
    .clk, .rst,
    .push_valid(f_valid), .push_ready(f_ready), .push_data(f_rec),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_data(q_rec)
  );

  hogc_norm u_norm (
    .clk, .rst,
    .rec_valid(q_valid), .rec_ready(q_ready), .rec(q_rec),
    .out_valid, .out_stall, .cell_row, .cell_col, .bin_index,
    .bin_count, .bin_value, .last_bin
  );

endmodule

// ----- verif/tb_hog_cell_orientation_histogram_core.sv -----
module tb_hog_cell_orientation_histogram_core;
  timeunit 1ns;
  timeprecision 1ps;
  import hogc_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 400;
  localparam int HOLD_CYCLES = 3000;

  typedef enum int {PAT_FLAT, PAT_RAMP, PAT_STRIPE, PAT_NOISE} pattern_e;

  typedef struct {
    pattern_e kind;
    int       a;
    int       b;
    int       npix;
    bit       fs;
    bit       typed;
  } stim_row_t;

  typedef struct {
    logic [3:0]  row;
    logic [3:0]  col;
    logic [3:0]  bin;
    logic [6:0]  count;
    logic [15:0] value;
    logic        last;
  } bin_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  pixel;
  logic        frame_start;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  cell_row;
  logic [3:0]  cell_col;
  logic [3:0]  bin_index;
  logic [6:0]  bin_count;
  logic [15:0] bin_value;
  logic        last_bin;

  hog_cell_orientation_histogram_core DUT (.*);

  // histogram model state
  logic [7:0]  line_old [IMAGE_SIZE];
  logic [7:0]  line_new [IMAGE_SIZE];
  int          hist [CELLS_PER_SIDE][NUM_BINS];
  int          pos_row;
  int          pos_col;
  logic [7:0]  prev_left;

  bin_result_t pending_bins[$];
  int          mismatches;
  int          bins_seen;
  int          cycles;
  int          burst_left;
  bit          hold_done;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int grad_bin(int gx, int gy);
    longint unsigned ys;
    longint unsigned mag;
    int b;
    if (gy < 0) begin
      gx = -gx;
      gy = -gy;
    end
    if (gy == 0) return 0;
    ys = longint'(gy) << 32;
    if (gx > 0) begin
      mag = gx;
      b = 0;
      for (int k = 0; k < TAN_COUNT; k++)
        if (ys >= longint'(BOUND_TAN[k]) * mag) b++;
      return b;
    end
    if (gx == 0) return HALF_BINS;
    mag = -gx;
    b = HALF_BINS;
    for (int k = 0; k < TAN_COUNT; k++)
      if (ys < longint'(BOUND_TAN[k]) * mag) b++;
    return b;
  endfunction

  function automatic int l2_scaled(longint unsigned c, longint unsigned s);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned t;
    lo = 0;
    hi = longint'(1) << FRACTION_BITS;
    if (s == 0) return 0;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      t = 2 * mid - 1;
      if (t * t * s <= ((4 * c * c) << (2 * FRACTION_BITS))) lo = mid;
      else hi = mid - 1;
    end
    return int'(lo);
  endfunction

  task automatic predict_pixel(logic [7:0] pix, bit fs, bit typed);
    int gr;
    int gx;
    int gy;
    int cc;
    int b;
    longint unsigned s;
    bin_result_t r;
    if (fs) begin
      pos_row = 0;
      pos_col = 0;
      foreach (hist[i, k]) hist[i][k] = 0;
    end
    if (pos_row == 0) begin
      line_new[pos_col] = pix;
    end else begin
      gr = pos_row - 1;
      gy = (gr == 0) ? 0 : int'(pix) - int'(line_old[pos_col]);
      gx = (pos_col == 0 || pos_col == IMAGE_SIZE - 1) ? 0
           : int'(line_new[pos_col + 1]) - int'(prev_left);
      prev_left = line_new[pos_col];
      line_old[pos_col] = line_new[pos_col];
      line_new[pos_col] = pix;
      if (gr < CELL_SPAN && pos_col < CELL_SPAN) begin
        cc = pos_col / CELL_SIZE;
        b = grad_bin(gx, gy);
        hist[cc][b]++;
        if (gr % CELL_SIZE == CELL_SIZE - 1 && pos_col % CELL_SIZE == CELL_SIZE - 1) begin
          s = 0;
          for (int k = 0; k < NUM_BINS; k++) s += hist[cc][k] * hist[cc][k];
          for (int k = 0; k < NUM_BINS; k++) begin
            r.row = 4'(gr / CELL_SIZE);
            r.col = 4'(cc);
            r.bin = 4'(k);
            r.count = 7'(hist[cc][k]);
            r.value = 16'(l2_scaled(hist[cc][k], s));
            if (typed) begin
              // flat gradient: every pixel in bin zero, unit norm
              r.count = (k == 0) ? 7'd64 : 7'd0;
              r.value = (k == 0) ? 16'd32768 : 16'd0;
            end
            r.last = (k == NUM_BINS - 1);
            pending_bins.push_back(r);
            hist[cc][k] = 0;
          end
        end
      end
    end
    pos_col++;
    if (pos_col >= IMAGE_SIZE) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= IMAGE_SIZE) begin
        pos_row = 0;
        foreach (hist[i, k]) hist[i][k] = 0;
      end
    end
  endtask

  task automatic send_pixel(logic [7:0] pix, bit fs, bit typed);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 600)
                                               : $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    pixel <= pix;
    frame_start <= fs;
    do @(posedge clk); while (in_stall);
    predict_pixel(pix, fs, typed);
  endtask

  function automatic logic [7:0] pattern_pixel(stim_row_t sr, int x, int y);
    case (sr.kind)
      PAT_FLAT: return 8'(sr.a);
      PAT_RAMP: return 8'(sr.a * x + sr.b * y);
      PAT_STRIPE: return (((x + sr.b * y) >> 1) & 1) ? 8'd255 : 8'd0;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic run_row(stim_row_t sr);
    for (int i = 0; i < sr.npix; i++)
      send_pixel(pattern_pixel(sr, i % IMAGE_SIZE, (i / IMAGE_SIZE) % IMAGE_SIZE),
                 sr.fs && i == 0, sr.typed);
  endtask

  stim_row_t stim_rows[] = '{
    '{PAT_RAMP,   1,   2, 1100, 1'b0, 1'b0},
    '{PAT_FLAT,   0,   0, 1100, 1'b1, 1'b1},
    '{PAT_FLAT,   255, 0, 1100, 1'b1, 1'b1},
    '{PAT_RAMP,   1,   0, 1100, 1'b1, 1'b1},
    '{PAT_RAMP,   0,   1, 1100, 1'b1, 1'b0},
    '{PAT_RAMP,   3,   1, 1100, 1'b1, 1'b0},
    '{PAT_RAMP,   2,   1, 1100, 1'b1, 1'b0},
    '{PAT_RAMP,   1,   1, 1100, 1'b1, 1'b0},
    '{PAT_RAMP,   1,   2, 1100, 1'b1, 1'b0},
    '{PAT_RAMP,   1,   7, 1100, 1'b1, 1'b0},
    '{PAT_RAMP,   255, 3, 1100, 1'b1, 1'b0},
    '{PAT_RAMP,   255, 1, 1100, 1'b1, 1'b0},
    '{PAT_RAMP,   254, 1, 1100, 1'b1, 1'b0},
    '{PAT_RAMP,   253, 1, 1100, 1'b1, 1'b0},
    '{PAT_STRIPE, 0,   0, 1100, 1'b1, 1'b0},
    '{PAT_STRIPE, 0,   1, 1100, 1'b1, 1'b0},
    '{PAT_NOISE,  0,   0, 700,  1'b1, 1'b0},
    '{PAT_NOISE,  0,   0, 1100, 1'b1, 1'b0},
    // runs past the end of the frame to cover the wrap
    '{PAT_RAMP,   1,   3, 17500, 1'b1, 1'b0}
  };

  initial begin
    stim_row_t sr;
    rst = 1'b1;
    in_valid = 1'b0;
    pixel = '0;
    frame_start = 1'b0;
    out_stall = 1'b0;
    mismatches = 0;
    bins_seen = 0;
    cycles = 0;
    burst_left = 0;
    hold_done = 0;
    pos_row = 0;
    pos_col = 0;
    prev_left = '0;
    foreach (hist[i, k]) hist[i][k] = 0;
    foreach (line_old[i]) begin
      line_old[i] = '0;
      line_new[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (stim_rows[i]) run_row(stim_rows[i]);
    in_valid <= 1'b0;
    wait (pending_bins.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (int seg = 0; seg < 6; seg++) begin
      sr.kind = ($urandom_range(0, 3) == 0) ? PAT_NOISE : PAT_RAMP;
      sr.a = $urandom_range(0, 255);
      sr.b = $urandom_range(0, 255);
      sr.fs = 1'b1;
      sr.typed = 1'b0;
      sr.npix = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 600)
                                            : $urandom_range(1040, 1300);
      for (int i = 0; i < sr.npix; i++)
        send_pixel(pattern_pixel(sr, i % IMAGE_SIZE, i / IMAGE_SIZE)
                   + 8'($urandom_range(0, 3)), i == 0, 1'b0);
    end
    in_valid <= 1'b0;
    wait (pending_bins.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int stall_mode;
    int mode_left;
    stall_mode = 0;
    mode_left = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!hold_done && bins_seen >= 200) begin
        hold_done = 1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    bin_result_t e;
    if (!rst && out_valid && !out_stall) begin
      bins_seen++;
      if (pending_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected bin beat: row %0d col %0d bin %0d", cell_row, cell_col,
                   bin_index);
      end else begin
        e = pending_bins.pop_front();
        if (cell_row !== e.row || cell_col !== e.col || bin_index !== e.bin ||
            bin_count !== e.count || bin_value !== e.value || last_bin !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("bin mismatch: exp %0d/%0d/%0d %0d %0d %0d, got %0d/%0d/%0d %0d %0d %0d",
                     e.row, e.col, e.bin, e.count, e.value, e.last, cell_row, cell_col,
                     bin_index, bin_count, bin_value, last_bin);
        end
      end
    end
  end

endmodule
